// ----- rtl/core/vector_magnitude_azimuth_macros.svh -----
// Assertion macros shared by the vector magnitude and azimuth block.
// Both expect the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef VECTOR_MAGNITUDE_AZIMUTH_MACROS_SVH
`define VECTOR_MAGNITUDE_AZIMUTH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vma: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vma: next-cycle check failed");

`endif

// ----- rtl/core/vma_pkg.sv -----
package vma_pkg;

    // Default fraction bits of the fixed-point inputs and width of the binary angles.
    localparam int DEFAULT_FRACTION_BITS = 16;
    localparam int DEFAULT_ANGLE_BITS    = 16;

    // Width of the threshold register.
    localparam int CFG_BITS = 16;

    // Number of CORDIC vectoring steps, one per pipeline stage.
    localparam int CORDIC_STEPS = 30;

    // Datapath widths: inputs are scaled to about 2^58, and the gain of the
    // rotation plus the quarter-turn stays well below 2^61.
    localparam int XW = 62;
    // Angle accumulator where 2^31 stands for pi; the sum can pass 2^31.
    localparam int ZW = 34;

    // atan(2^-i) in units where 2^31 stands for pi, rounded.
    localparam logic [29:0] ATAN_UNITS [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1
    };

endpackage

// ----- rtl/core/vma_sqrt_pipe.sv -----
module vma_sqrt_pipe #(
    parameter int FRACTION_BITS = vma_pkg::DEFAULT_FRACTION_BITS,
    parameter int DEPTH         = vma_pkg::CORDIC_STEPS + 1
) (
    input  logic                            i_clk,
    input  logic [DEPTH-1:0]                i_en,
    input  logic signed [FRACTION_BITS+1:0] i_east,
    input  logic signed [FRACTION_BITS+1:0] i_north,
    output logic [FRACTION_BITS+1:0]        o_magnitude
);
    import vma_pkg::*;

    localparam int IN_BITS     = FRACTION_BITS + 2;
    localparam int RW          = 2 * IN_BITS;
    localparam int ROUND_STAGE = IN_BITS + 2;

    logic signed [RW-1:0] w_sq_e;
    logic signed [RW-1:0] w_sq_n;
    logic [RW-1:0]        r_sq_e;
    logic [RW-1:0]        r_sq_n;
    logic [RW-1:0]        r_rem  [1:DEPTH-1];
    logic [IN_BITS-1:0]   r_root [1:DEPTH-1];

    // Stage 0: square both components.
    assign w_sq_e = RW'(i_east) * RW'(i_east);
    assign w_sq_n = RW'(i_north) * RW'(i_north);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sq_e <= w_sq_e;
            r_sq_n <= w_sq_n;
        end
    end

    // Stage 1: the sum of squares becomes the starting remainder.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rem[1]  <= r_sq_e + r_sq_n;
            r_root[1] <= '0;
        end
    end

    // One root bit per stage, most significant first, then rounding.
    for (genvar k = 2; k < DEPTH; k++) begin : g_stage
        if (k <= IN_BITS + 1) begin : g_digit
            localparam int B = IN_BITS + 1 - k;
            logic [RW-1:0] w_trial;
            logic [RW:0]   w_diff;

            // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
            assign w_trial = (RW'(r_root[k-1]) << (B + 1)) + (RW'(1) << (2 * B));
            assign w_diff  = {1'b0, r_rem[k-1]} - {1'b0, w_trial};

            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    if (!w_diff[RW]) begin
                        r_rem[k]  <= w_diff[RW-1:0];
                        r_root[k] <= r_root[k-1] | (IN_BITS'(1) << B);
                    end else begin
                        r_rem[k]  <= r_rem[k-1];
                        r_root[k] <= r_root[k-1];
                    end
                end
            end
        end else if (k == ROUND_STAGE) begin : g_round
            // Round to nearest: step up when the remainder exceeds the root.
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rem[k] <= r_rem[k-1];
                    if (r_rem[k-1] > RW'(r_root[k-1])) begin
                        r_root[k] <= r_root[k-1] + IN_BITS'(1);
                    end else begin
                        r_root[k] <= r_root[k-1];
                    end
                end
            end
        end else begin : g_hold
            // Delay stages that keep step with the angle pipeline.
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rem[k]  <= r_rem[k-1];
                    r_root[k] <= r_root[k-1];
                end
            end
        end
    end

    assign o_magnitude = r_root[DEPTH-1];

endmodule

// ----- rtl/core/vma_cordic_pipe.sv -----
module vma_cordic_pipe #(
    parameter int FRACTION_BITS = vma_pkg::DEFAULT_FRACTION_BITS,
    parameter int ANGLE_BITS    = vma_pkg::DEFAULT_ANGLE_BITS,
    parameter int DEPTH         = vma_pkg::CORDIC_STEPS + 1
) (
    input  logic                            i_clk,
    input  logic [DEPTH-1:0]                i_en,
    input  logic signed [FRACTION_BITS+1:0] i_east,
    input  logic signed [FRACTION_BITS+1:0] i_north,
    output logic [ANGLE_BITS-1:0]           o_theta
);
    import vma_pkg::*;

    localparam int IN_BITS = FRACTION_BITS + 2;
    localparam int GUARD   = 59 - IN_BITS;

    // The rounding offset is folded into the starting angle, since the
    // accumulator only ever adds or subtracts table constants.
    localparam logic signed [ZW-1:0] Z_ROUND   = ZW'(1) << (31 - ANGLE_BITS);
    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(1) << 30;

    logic signed [XW-1:0] w_e;
    logic signed [XW-1:0] w_n;
    logic signed [XW-1:0] w_x0;
    logic signed [XW-1:0] w_y0;
    logic signed [ZW-1:0] w_z0;

    logic signed [XW-1:0] r_x [0:CORDIC_STEPS-1];
    logic signed [XW-1:0] r_y [0:CORDIC_STEPS-1];
    logic signed [ZW-1:0] r_z [0:DEPTH-1];

    // Stage 0: scale up, and turn vectors with a negative east component
    // by a quarter turn into the right half plane.
    assign w_e = XW'(i_east) <<< GUARD;
    assign w_n = XW'(i_north) <<< GUARD;

    always_comb begin
        w_x0 = w_e;
        w_y0 = w_n;
        w_z0 = Z_ROUND;
        if (i_east[IN_BITS-1]) begin
            if (!i_north[IN_BITS-1]) begin
                w_x0 = w_n;
                w_y0 = -w_e;
                w_z0 = Z_ROUND + Z_QUARTER;
            end else begin
                w_x0 = -w_n;
                w_y0 = w_e;
                w_z0 = Z_ROUND - Z_QUARTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0] <= w_x0;
            r_y[0] <= w_y0;
            r_z[0] <= w_z0;
        end
    end

    // One vectoring step per stage, driving y toward zero.
    for (genvar k = 1; k < DEPTH; k++) begin : g_stage
        if (k <= CORDIC_STEPS) begin : g_step
            localparam int I = k - 1;
            logic signed [XW-1:0] w_xs;
            logic signed [XW-1:0] w_ys;
            logic signed [ZW-1:0] w_t;
            logic                 w_up;

            assign w_xs = r_x[I] >>> I;
            assign w_ys = r_y[I] >>> I;
            assign w_t  = ZW'(ATAN_UNITS[I]);
            assign w_up = !r_y[I][XW-1];

            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_z[k] <= w_up ? (r_z[I] + w_t) : (r_z[I] - w_t);
                end
            end

            if (k < CORDIC_STEPS) begin : g_xy
                always_ff @(posedge i_clk) begin
                    if (i_en[k]) begin
                        r_x[k] <= w_up ? (r_x[I] + w_ys) : (r_x[I] - w_ys);
                        r_y[k] <= w_up ? (r_y[I] - w_xs) : (r_y[I] + w_xs);
                    end
                end
            end
        end else begin : g_hold
            // Delay stages that keep step with the magnitude pipeline.
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_z[k] <= r_z[k-1];
                end
            end
        end
    end

    // The angle code is a plain bit field of the rounded accumulator.
    assign o_theta = r_z[DEPTH-1][31 -: ANGLE_BITS];

endmodule

// ----- rtl/core/vector_magnitude_azimuth.sv -----
// Converts an east/north slowness vector to its length and to compass and back azimuths.
// The block is a single pipeline: one item may be accepted in every cycle while
// o_stall is low. Its depth is set by the 30-step CORDIC chain, one step per stage,
// or for wide inputs by the digit-by-digit square root, one root bit per stage. Each
// stage holds its item until the next stage has room, so an empty stage is filled
// even while the output is stalled, and o_stall rises only when every stage is full.
// The threshold register is sampled at the last stage; write it only while no items
// are in flight.
`include "vector_magnitude_azimuth_macros.svh"

module vector_magnitude_azimuth #(
    parameter int FRACTION_BITS = vma_pkg::DEFAULT_FRACTION_BITS,
    parameter int ANGLE_BITS    = vma_pkg::DEFAULT_ANGLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Threshold register
    input  logic                            i_cfg_wr_en,
    input  logic [vma_pkg::CFG_BITS-1:0]    i_cfg_wr_data,
    // Input items
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [FRACTION_BITS+1:0] i_east_slowness,
    input  logic signed [FRACTION_BITS+1:0] i_north_slowness,
    input  logic signed [ANGLE_BITS-1:0]    i_fallback_azimuth,
    // Result items
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [FRACTION_BITS+1:0]        o_magnitude,
    output logic signed [ANGLE_BITS-1:0]    o_azimuth_out,
    output logic signed [ANGLE_BITS-1:0]    o_back_azimuth,
    output logic                            o_used_fallback
);
    import vma_pkg::*;

    localparam int IN_BITS    = FRACTION_BITS + 2;
    localparam int SQRT_LAST  = IN_BITS + 2;
    localparam int CORE_DEPTH = ((SQRT_LAST > CORDIC_STEPS) ? SQRT_LAST : CORDIC_STEPS) + 1;
    localparam int CMP_W      = (IN_BITS > CFG_BITS) ? IN_BITS : CFG_BITS;

    localparam logic [ANGLE_BITS-1:0] QUARTER_ANGLE = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] HALF_ANGLE    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] THREE_QUARTER = QUARTER_ANGLE + HALF_ANGLE;

    logic [CFG_BITS-1:0]   r_small_magnitude;
    logic [CORE_DEPTH:0]   r_valid;
    logic [CORE_DEPTH:0]   w_en;
    logic [CORE_DEPTH:0]   w_valid_shift;
    logic [ANGLE_BITS-1:0] r_fb [0:CORE_DEPTH-1];

    logic [IN_BITS-1:0]    w_mag;
    logic [ANGLE_BITS-1:0] w_theta;
    logic [ANGLE_BITS-1:0] w_fb;
    logic                  w_used;
    logic [ANGLE_BITS-1:0] w_az;
    logic [ANGLE_BITS-1:0] w_back;

    logic [IN_BITS-1:0]    r_magnitude;
    logic [ANGLE_BITS-1:0] r_azimuth_out;
    logic [ANGLE_BITS-1:0] r_back_azimuth;
    logic                  r_used_fallback;

    logic [ANGLE_BITS-1:0] w_angle_gap;
    logic [ANGLE_BITS-1:0] w_angle_sum;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_magnitude <= '0;
        end else if (i_cfg_wr_en) begin
            r_small_magnitude <= i_cfg_wr_data;
        end
    end

    // A stage may load when it, or some stage after it, is empty, or when the
    // output item is being taken.
    for (genvar k = 0; k <= CORE_DEPTH; k++) begin : g_en
        assign w_en[k] = ~(&r_valid[CORE_DEPTH:k]) | ~i_stall;
    end

    assign w_valid_shift = {r_valid[CORE_DEPTH-1:0], i_valid};
    assign o_stall       = ~w_en[0];

    // Valid bits travel with the items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k <= CORE_DEPTH; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= w_valid_shift[k];
                end
            end
        end
    end

    // The fallback azimuth rides alongside the arithmetic.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_fb[0] <= i_fallback_azimuth;
        end
        for (int k = 1; k < CORE_DEPTH; k++) begin
            if (w_en[k]) begin
                r_fb[k] <= r_fb[k-1];
            end
        end
    end

    // Length by a digit-serial square root, angle by CORDIC vectoring.
    vma_sqrt_pipe #(
        .FRACTION_BITS (FRACTION_BITS),
        .DEPTH         (CORE_DEPTH)
    ) u_sqrt (
        .i_clk       (i_clk),
        .i_en        (w_en[CORE_DEPTH-1:0]),
        .i_east      (i_east_slowness),
        .i_north     (i_north_slowness),
        .o_magnitude (w_mag)
    );

    vma_cordic_pipe #(
        .FRACTION_BITS (FRACTION_BITS),
        .ANGLE_BITS    (ANGLE_BITS),
        .DEPTH         (CORE_DEPTH)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en[CORE_DEPTH-1:0]),
        .i_east  (i_east_slowness),
        .i_north (i_north_slowness),
        .o_theta (w_theta)
    );

    // Last stage: threshold test and conversion to compass angles.
    assign w_fb   = r_fb[CORE_DEPTH-1];
    assign w_used = CMP_W'(w_mag) <= CMP_W'(r_small_magnitude);
    assign w_az   = w_used ? w_fb : (QUARTER_ANGLE - w_theta);
    assign w_back = w_used ? (HALF_ANGLE - w_fb) : (THREE_QUARTER - w_theta);

    always_ff @(posedge i_clk) begin
        if (w_en[CORE_DEPTH]) begin
            r_magnitude     <= w_mag;
            r_azimuth_out   <= w_az;
            r_back_azimuth  <= w_back;
            r_used_fallback <= w_used;
        end
    end

    assign o_valid         = r_valid[CORE_DEPTH];
    assign o_magnitude     = r_magnitude;
    assign o_azimuth_out   = r_azimuth_out;
    assign o_back_azimuth  = r_back_azimuth;
    assign o_used_fallback = r_used_fallback;

    // Difference and sum of the two output angles, for the checks below.
    assign w_angle_gap = r_back_azimuth - r_azimuth_out;
    assign w_angle_sum = r_back_azimuth + r_azimuth_out;

    // An item in the last core stage reaches the output when the output is not stalled.
    `VMA_ASSERT_NEXT(a_core_drains, r_valid[CORE_DEPTH-1] && !i_stall, o_valid)
    // Input is held off only when every stage holds an item.
    `VMA_ASSERT_NOW(a_stall_only_when_full, o_stall, &r_valid)
    // From the vector angle, the back azimuth lies half a turn from the azimuth.
    `VMA_ASSERT_NOW(a_back_opposite, o_valid && !o_used_fallback, w_angle_gap == HALF_ANGLE)
    // From the fallback, the two angles add up to half a turn.
    `VMA_ASSERT_NOW(a_back_mirrored, o_valid && o_used_fallback, w_angle_sum == HALF_ANGLE)

endmodule

// ----- tb/vector_magnitude_azimuth_tb.sv -----
module vector_magnitude_azimuth_tb;

    localparam int FRAC_BITS    = vma_pkg::DEFAULT_FRACTION_BITS;
    localparam int ANG_BITS     = vma_pkg::DEFAULT_ANGLE_BITS;
    localparam int IN_W         = FRAC_BITS + 2;
    localparam int GUARD_SHIFT  = 59 - IN_W;
    localparam int ANG_SHIFT    = 32 - ANG_BITS;
    localparam int PIPE_LATENCY = (FRAC_BITS + 5 > 31) ? FRAC_BITS + 5 : 31;
    localparam int NUM_DIRECTED = 24;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 90;

    // Quarter turn, half turn and three quarter turns as binary angles.
    localparam logic [ANG_BITS-1:0] QUARTER_TURN       = ANG_BITS'(1) << (ANG_BITS - 2);
    localparam logic [ANG_BITS-1:0] HALF_TURN          = ANG_BITS'(1) << (ANG_BITS - 1);
    localparam logic [ANG_BITS-1:0] THREE_QUARTER_TURN = QUARTER_TURN + HALF_TURN;

    typedef struct packed {
        logic [IN_W-1:0]            magnitude;
        logic signed [ANG_BITS-1:0] azimuth_out;
        logic signed [ANG_BITS-1:0] back_azimuth;
        logic                       used_fallback;
    } t_polar;

    typedef struct {
        bit                         wr_thr;
        logic [vma_pkg::CFG_BITS-1:0] thr;
        logic signed [IN_W-1:0]     east;
        logic signed [IN_W-1:0]     north;
        logic signed [ANG_BITS-1:0] fallback;
        bit                         typed;
        t_polar                     want;
    } t_stim_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_wr_en;
    logic [vma_pkg::CFG_BITS-1:0]    i_cfg_wr_data;
    logic                            i_valid;
    logic                            o_stall;
    logic signed [IN_W-1:0]          i_east_slowness;
    logic signed [IN_W-1:0]          i_north_slowness;
    logic signed [ANG_BITS-1:0]      i_fallback_azimuth;
    logic                            o_valid;
    logic                            i_stall;
    logic [IN_W-1:0]                 o_magnitude;
    logic signed [ANG_BITS-1:0]      o_azimuth_out;
    logic signed [ANG_BITS-1:0]      o_back_azimuth;
    logic                            o_used_fallback;

    // Shadow of the threshold register and the results still to come.
    logic [vma_pkg::CFG_BITS-1:0]    threshold;
    t_polar                          pending_polar [$];
    int                              error_count;
    int                              results_checked;
    int                              fallback_seen;
    int                              sender_idle_pct;
    int                              stall_pct;
    t_stim_row                       directed_rows [NUM_DIRECTED];

    vector_magnitude_azimuth #(
        .FRACTION_BITS(FRAC_BITS),
        .ANGLE_BITS   (ANG_BITS)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_east_slowness   (i_east_slowness),
        .i_north_slowness  (i_north_slowness),
        .i_fallback_azimuth(i_fallback_azimuth),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_magnitude       (o_magnitude),
        .o_azimuth_out     (o_azimuth_out),
        .o_back_azimuth    (o_back_azimuth),
        .o_used_fallback   (o_used_fallback)
    );

    // Clock with a period of 8.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    // Rounded integer square root, one result bit per iteration.
    function automatic longint unsigned isqrt_round(longint unsigned s);
        longint unsigned rest;
        longint unsigned root;
        longint unsigned probe;
        rest  = s;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rest) probe = probe >> 2;
        while (probe != 0) begin
            if (rest >= root + probe) begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        if (rest > root) root = root + 1;
        return root;
    endfunction

    // CORDIC vectoring angle in units where 2^31 is pi, reduced to a binary angle.
    function automatic longint cordic_theta(logic signed [IN_W-1:0] east,
                                            logic signed [IN_W-1:0] north);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint t;
        x = longint'(east) <<< GUARD_SHIFT;
        y = longint'(north) <<< GUARD_SHIFT;
        z = 0;
        // Vectors in the left half plane are first turned by a quarter turn.
        if (x < 0) begin
            if (y >= 0) begin
                t = x;
                x = y;
                y = -t;
                z = 64'sd1 <<< 30;
            end else begin
                t = x;
                x = -y;
                y = t;
                z = -(64'sd1 <<< 30);
            end
        end
        for (int i = 0; i < vma_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(vma_pkg::ATAN_UNITS[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(vma_pkg::ATAN_UNITS[i]);
            end
        end
        return (z + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    endfunction

    // Length and azimuths of one vector under the current threshold.
    function automatic t_polar predict_polar(logic signed [IN_W-1:0] east,
                                             logic signed [IN_W-1:0] north,
                                             logic signed [ANG_BITS-1:0] fallback,
                                             logic [vma_pkg::CFG_BITS-1:0] thr);
        t_polar          res;
        longint          ae;
        longint          an;
        longint unsigned mag;
        logic [ANG_BITS-1:0] theta;
        ae  = (east < 0) ? -longint'(east) : longint'(east);
        an  = (north < 0) ? -longint'(north) : longint'(north);
        mag = isqrt_round(longint'(ae * ae + an * an));
        res.magnitude = mag[IN_W-1:0];
        if (mag <= longint'(thr)) begin
            res.used_fallback = 1'b1;
            res.azimuth_out   = fallback;
            res.back_azimuth  = HALF_TURN - fallback;
        end else begin
            theta = ANG_BITS'(cordic_theta(east, north));
            res.used_fallback = 1'b0;
            res.azimuth_out   = QUARTER_TURN - theta;
            res.back_azimuth  = THREE_QUARTER_TURN - theta;
        end
        return res;
    endfunction

    // Receiver stall, redrawn every cycle at the falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_polar got;
        t_polar want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_magnitude, o_azimuth_out, o_back_azimuth, o_used_fallback};
            if (pending_polar.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: mag %0d az %0d back %0d fb %0b",
                         $time, got.magnitude, got.azimuth_out, got.back_azimuth,
                         got.used_fallback);
            end else begin
                want = pending_polar.pop_front();
                results_checked++;
                if (got.used_fallback) fallback_seen++;
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch: expected mag %0d az %0d back %0d fb %0b",
                             $time, want.magnitude, want.azimuth_out, want.back_azimuth,
                             want.used_fallback);
                    $display("%0t:           actual   mag %0d az %0d back %0d fb %0b",
                             $time, got.magnitude, got.azimuth_out, got.back_azimuth,
                             got.used_fallback);
                end
            end
        end
    end

    // Offer one item, called and left at a falling edge; valid stays high for a next item.
    task automatic send_vector(input logic signed [IN_W-1:0] east,
                               input logic signed [IN_W-1:0] north,
                               input logic signed [ANG_BITS-1:0] fallback,
                               input bit typed, input t_polar typed_want);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_east_slowness    <= east;
        i_north_slowness   <= north;
        i_fallback_azimuth <= fallback;
        do @(posedge i_clk); while (o_stall);
        pending_polar.push_back(typed ? typed_want
                                      : predict_polar(east, north, fallback, threshold));
        @(negedge i_clk);
    endtask

    // Stop sending and wait until the pipeline has emptied.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (pending_polar.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 4) @(negedge i_clk);
    endtask

    // Threshold write, for use only while the pipeline is empty; the task itself does not enforce this.
    task automatic write_threshold(input logic [vma_pkg::CFG_BITS-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        threshold      = value;
    endtask

    // Random vector drawn from a mix of full range, small, axis, diagonal, near-threshold and corners.
    task automatic pick_random_vector(output logic signed [IN_W-1:0] east,
                                      output logic signed [IN_W-1:0] north,
                                      output logic signed [ANG_BITS-1:0] fallback);
        logic signed [IN_W-1:0] corners [5];
        logic signed [IN_W-1:0] raw;
        int                     kind;
        int                     m;
        corners  = '{IN_W'(-(1 <<< (IN_W - 1))), IN_W'((1 <<< (IN_W - 1)) - 1),
                     IN_W'(0), IN_W'(-1), IN_W'(1)};
        kind     = $urandom_range(0, 99);
        fallback = ANG_BITS'($urandom);
        east     = IN_W'($urandom);
        north    = IN_W'($urandom);
        if (kind < 40) begin
            // Full range, already drawn.
        end else if (kind < 60) begin
            raw   = IN_W'($urandom);
            east  = raw >>> $urandom_range(0, IN_W - 1);
            raw   = IN_W'($urandom);
            north = raw >>> $urandom_range(0, IN_W - 1);
        end else if (kind < 70) begin
            case ($urandom_range(0, 2))
                0: north = 0;
                1: east = 0;
                default: north = ($urandom_range(0, 1) != 0) ? east : -east;
            endcase
        end else if (kind < 85) begin
            // Length one below, at or one above the threshold.
            m = int'(threshold) + int'($urandom_range(0, 2)) - 1;
            if (m < 0) m = 0;
            east  = 0;
            north = 0;
            case ($urandom_range(0, 3))
                0: east = IN_W'(m);
                1: east = -IN_W'(m);
                2: north = IN_W'(m);
                default: north = -IN_W'(m);
            endcase
        end else begin
            east  = corners[$urandom_range(0, 4)];
            north = corners[$urandom_range(0, 4)];
        end
    endtask

    // Stimulus and end of run.
    initial begin
        logic signed [IN_W-1:0]     east;
        logic signed [IN_W-1:0]     north;
        logic signed [ANG_BITS-1:0] fallback;
        logic [vma_pkg::CFG_BITS-1:0] phase_thr [NUM_PHASES];
        int                         idle_mode;

        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        i_valid            = 1'b0;
        i_east_slowness    = '0;
        i_north_slowness   = '0;
        i_fallback_azimuth = '0;
        threshold          = '0;
        error_count        = 0;
        results_checked    = 0;
        fallback_seen      = 0;
        sender_idle_pct    = 0;
        stall_pct          = 0;

        // Directed rows: zero vectors with extreme fallbacks, corners, axes, the
        // half-turn direction, and vectors at and just past the threshold.
        directed_rows = '{
            '{1, 16'd0, 18'sd0, 18'sd0, 16'sd1234, 1, '{18'd0, 16'sd1234, 16'sd31534, 1'b1}},
            '{0, 16'd0, 18'sd0, 18'sd0, -16'sd32768, 1, '{18'd0, -16'sd32768, 16'sd0, 1'b1}},
            '{0, 16'd0, 18'sd0, 18'sd0, 16'sd32767, 1, '{18'd0, 16'sd32767, 16'sd1, 1'b1}},
            '{0, 16'd0, 18'sd0, 18'sd0, 16'sd0, 1, '{18'd0, 16'sd0, -16'sd32768, 1'b1}},
            '{0, 16'd0, 18'sd65536, 18'sd0, 16'sd0, 0, '0},
            '{0, 16'd0, 18'sd0, 18'sd65536, 16'sd0, 0, '0},
            '{0, 16'd0, -18'sd65536, 18'sd0, 16'sd0, 0, '0},
            '{0, 16'd0, 18'sd0, -18'sd65536, 16'sd0, 0, '0},
            '{0, 16'd0, 18'sd131071, 18'sd131071, 16'sd0, 0, '0},
            '{0, 16'd0, -18'sd131072, -18'sd131072, 16'sd0, 0, '0},
            '{0, 16'd0, -18'sd131072, 18'sd131071, 16'sd0, 0, '0},
            '{0, 16'd0, 18'sd131071, -18'sd131072, 16'sd0, 0, '0},
            '{0, 16'd0, -18'sd131072, 18'sd0, 16'sd0, 0, '0},
            '{0, 16'd0, 18'sd0, -18'sd131072, 16'sd0, 0, '0},
            '{0, 16'd0, 18'sd1, 18'sd0, 16'sd0, 0, '0},
            '{0, 16'd0, -18'sd1, 18'sd0, 16'sd0, 0, '0},
            '{0, 16'd0, -18'sd1, -18'sd1, 16'sd0, 0, '0},
            '{0, 16'd0, 18'sd46341, -18'sd46341, 16'sd0, 0, '0},
            '{1, 16'd100, 18'sd60, 18'sd80, -16'sd100, 1,
              '{18'd100, -16'sd100, -16'sd32668, 1'b1}},
            '{0, 16'd100, 18'sd100, 18'sd0, 16'sd5, 1, '{18'd100, 16'sd5, 16'sd32763, 1'b1}},
            '{0, 16'd100, 18'sd101, 18'sd0, 16'sd5, 0, '0},
            '{0, 16'd100, -18'sd70, -18'sd71, 16'sd7, 0, '0},
            '{1, 16'd65535, 18'sd65535, 18'sd0, -16'sd1, 1,
              '{18'd65535, -16'sd1, -16'sd32767, 1'b1}},
            '{0, 16'd65535, 18'sd0, -18'sd65536, 16'sd9, 0, '0}
        };

        // Hold reset, then release it at a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, no idling on either side.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].wr_thr) begin
                drain_pipeline();
                write_threshold(directed_rows[r].thr);
            end
            send_vector(directed_rows[r].east, directed_rows[r].north,
                        directed_rows[r].fallback, directed_rows[r].typed,
                        directed_rows[r].want);
        end

        // Random phases, each with its own threshold and handshake pattern.
        phase_thr = '{16'd0, 16'd65535, 16'($urandom_range(1, 65534)),
                      16'($urandom_range(1, 300)), 16'($urandom_range(30000, 40000))};
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_pipeline();
            write_threshold(phase_thr[p]);
            idle_mode = p % 4;
            sender_idle_pct = (idle_mode == 1) ? 48 : (idle_mode == 3) ? 28 : 0;
            stall_pct       = (idle_mode == 2) ? 48 : (idle_mode == 3) ? 28 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Once mid-phase, hold off until every result is back.
                if (p == 2 && k == PHASE_ITEMS / 2) drain_pipeline();
                pick_random_vector(east, north, fallback);
                send_vector(east, north, fallback, 0, '0);
            end
        end

        drain_pipeline();
        $display("Checked %0d results (%0d via the small-vector fallback) over %0d phases,",
                 results_checked, fallback_seen, NUM_PHASES + 1);
        $display("with thresholds from 0 to 65535 and stalls on both channels.");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
